>>> hdl/rrwd_pkg.sv
// Shared types and codes of the round-robin worker dispatcher.
// No dependencies; used by rrwd_scan and round_robin_worker_dispatcher_core.
package rrwd_pkg;

	localparam int unsigned MAX_WORKERS_DEF = 16;

	typedef enum logic [1:0] {
		REQ_PUT    = 2'd0,
		REQ_NOTIFY = 2'd1,
		REQ_GET    = 2'd2,
		REQ_INDONE = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		STATUS_ACCEPTED   = 3'd0,
		STATUS_DISPATCHED = 3'd1,
		STATUS_COLLECTED  = 3'd2,
		STATUS_NO_FREE    = 3'd3,
		STATUS_NONE_READY = 3'd4,
		STATUS_FINISHED   = 3'd5,
		STATUS_BAD_INDEX  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} fsm_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [3:0]  worker_index;
		logic [15:0] request_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  chosen_worker;
		logic [15:0] tag_out;
	} out_item_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_sts_t;

	localparam logic [0:0] REG_ACTIVE_WORKERS = 1'b0;

endpackage

>>> hdl/rrwd_scan.sv
// Iterative round-robin bit scan: tests one mask bit per cycle from a start index.
// Depends on rrwd_pkg.
module rrwd_scan #(
	parameter int unsigned MAX_WORKERS = rrwd_pkg::MAX_WORKERS_DEF,
	parameter int unsigned IW = $clog2(MAX_WORKERS),
	parameter int unsigned NW = (IW + 1 > 5) ? IW + 1 : 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [MAX_WORKERS-1:0] mask,
	input  logic [IW-1:0]          start_idx,
	input  logic [NW-1:0]          n,
	output logic [IW-1:0]          idx,
	output rrwd_pkg::scan_sts_t    sts
);

	logic          run_q;
	logic [IW-1:0] idx_q;
	logic [NW-1:0] cnt_q;
	logic          hit;
	logic          last;
	logic [IW-1:0] idx_nxt;

	assign hit  = mask[idx_q];
	assign last = (cnt_q == NW'(1));
	assign idx_nxt = (NW'(idx_q) + NW'(1) >= n) ? '0 : IW'(NW'(idx_q) + NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			idx_q <= (NW'(start_idx) >= n) ? '0 : start_idx;
			cnt_q <= n;
		end else if (run_q) begin
			if (hit || last) begin
				run_q <= 1'b0;
			end else begin
				idx_q <= idx_nxt;
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	assign idx       = idx_q;
	assign sts.done  = run_q && (hit || last);
	assign sts.found = run_q && hit;

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q != '0) && (NW'(idx_q) < n))
		else $error("scan ran past the active range");

	a_scan_found_hit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.found |-> mask[idx_q] && sts.done)
		else $error("scan reported a clear bit");

endmodule

>>> hdl/round_robin_worker_dispatcher_core.sv
// Top level of the round-robin worker dispatcher: sequencer, worker masks, APB register.
// Depends on rrwd_pkg and rrwd_scan.
//
// Channel   Direction  Handshake                        Payload
// command   in         start & !busy                    item (in_item_t)
// result    out        strobe, one cycle, no stall      result (out_item_t)
// config    in         psel & penable & pwrite (APB)    pwdata -> active_workers
//
// A notify, an input-done and a finished get go from start through the exec state to the strobe.
// A put or a get that scans tests at most n worker bits, n the active worker count:
// the scan unit tests one worker bit per cycle from the rotating pointer.
// strobe rises in the cycle busy falls; a new transaction may start in that cycle.
// Reset frees all workers, clears done bits, pointers and counts, sets the active worker register to 16.
module round_robin_worker_dispatcher_core #(
	parameter int unsigned MAX_WORKERS = rrwd_pkg::MAX_WORKERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rrwd_pkg::in_item_t  item,
	output logic                busy,
	output logic                strobe,
	output rrwd_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int unsigned IW = $clog2(MAX_WORKERS);
	localparam int unsigned NW = (IW + 1 > 5) ? IW + 1 : 5;
	localparam logic [NW-1:0] MAXN = NW'(MAX_WORKERS);

	rrwd_pkg::fsm_t      state_q, state_d;
	rrwd_pkg::in_item_t  item_q;
	rrwd_pkg::out_item_t result_q, res_d;
	logic                strobe_q;

	logic [4:0]             active_q;
	logic [MAX_WORKERS-1:0] free_mask_q;
	logic [MAX_WORKERS-1:0] done_mask_q;
	logic [IW-1:0]          put_ptr_q;
	logic [IW-1:0]          get_ptr_q;
	logic [31:0]            issued_q;
	logic [31:0]            collected_q;
	logic                   in_fin_q;

	logic [NW-1:0] n;
	logic [NW-1:0] widx_w;
	logic [IW-1:0] widx;
	logic          notify_bad;
	logic          get_fin;
	logic          is_put;
	logic          go;
	logic          fin;
	logic          do_put;
	logic          do_notify;
	logic          do_get;
	logic          do_indone;
	logic [IW-1:0] scan_idx;
	logic [IW-1:0] scan_nxt;
	rrwd_pkg::scan_sts_t scan_sts;
	logic          cfg_wr;

	assign n = (active_q == 5'd0) ? NW'(1) : ((NW'(active_q) > MAXN) ? MAXN : NW'(active_q));

	assign widx_w     = NW'(item_q.worker_index);
	assign widx       = widx_w[IW-1:0];
	assign notify_bad = (widx_w >= n) || done_mask_q[widx] || free_mask_q[widx];
	assign get_fin    = in_fin_q && (issued_q == collected_q);
	assign is_put     = (item_q.req_type == rrwd_pkg::REQ_PUT);
	assign scan_nxt   = (NW'(scan_idx) + NW'(1) >= n) ? '0 : IW'(NW'(scan_idx) + NW'(1));

	rrwd_scan #(
		.MAX_WORKERS(MAX_WORKERS),
		.IW(IW),
		.NW(NW)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.mask(is_put ? free_mask_q : done_mask_q),
		.start_idx(is_put ? put_ptr_q : get_ptr_q),
		.n(n),
		.idx(scan_idx),
		.sts(scan_sts)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrwd_pkg::S_IDLE: begin
				if (start) state_d = rrwd_pkg::S_EXEC;
			end
			rrwd_pkg::S_EXEC: begin
				if (is_put || (item_q.req_type == rrwd_pkg::REQ_GET && !get_fin)) begin
					state_d = rrwd_pkg::S_SCAN;
				end else begin
					state_d = rrwd_pkg::S_IDLE;
				end
			end
			rrwd_pkg::S_SCAN: begin
				if (scan_sts.done) state_d = rrwd_pkg::S_IDLE;
			end
			default: state_d = rrwd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		go        = 1'b0;
		fin       = 1'b0;
		do_put    = 1'b0;
		do_notify = 1'b0;
		do_get    = 1'b0;
		do_indone = 1'b0;
		res_d     = '0;
		case (state_q)
			rrwd_pkg::S_EXEC: begin
				case (item_q.req_type)
					rrwd_pkg::REQ_PUT: go = 1'b1;
					rrwd_pkg::REQ_NOTIFY: begin
						fin = 1'b1;
						if (notify_bad) begin
							res_d.status = rrwd_pkg::STATUS_BAD_INDEX;
						end else begin
							do_notify           = 1'b1;
							res_d.status        = rrwd_pkg::STATUS_ACCEPTED;
							res_d.chosen_worker = 4'(widx);
						end
					end
					rrwd_pkg::REQ_GET: begin
						if (get_fin) begin
							fin          = 1'b1;
							res_d.status = rrwd_pkg::STATUS_FINISHED;
						end else begin
							go = 1'b1;
						end
					end
					rrwd_pkg::REQ_INDONE: begin
						fin          = 1'b1;
						do_indone    = 1'b1;
						res_d.status = rrwd_pkg::STATUS_ACCEPTED;
					end
					default: ;
				endcase
			end
			rrwd_pkg::S_SCAN: begin
				if (scan_sts.done) begin
					fin = 1'b1;
					if (is_put) begin
						if (scan_sts.found) begin
							do_put              = 1'b1;
							res_d.status        = rrwd_pkg::STATUS_DISPATCHED;
							res_d.chosen_worker = 4'(scan_idx);
							res_d.tag_out       = item_q.request_tag;
						end else begin
							res_d.status = rrwd_pkg::STATUS_NO_FREE;
						end
					end else begin
						if (scan_sts.found) begin
							do_get              = 1'b1;
							res_d.status        = rrwd_pkg::STATUS_COLLECTED;
							res_d.chosen_worker = 4'(scan_idx);
						end else begin
							res_d.status = rrwd_pkg::STATUS_NONE_READY;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrwd_pkg::S_IDLE;
			strobe_q    <= 1'b0;
			free_mask_q <= '1;
			done_mask_q <= '0;
			put_ptr_q   <= '0;
			get_ptr_q   <= '0;
			issued_q    <= '0;
			collected_q <= '0;
			in_fin_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= fin;
			if (do_put) begin
				free_mask_q[scan_idx] <= 1'b0;
				issued_q              <= issued_q + 32'd1;
				put_ptr_q             <= scan_nxt;
			end
			if (do_notify) done_mask_q[widx] <= 1'b1;
			if (do_get) begin
				done_mask_q[scan_idx] <= 1'b0;
				free_mask_q[scan_idx] <= 1'b1;
				collected_q           <= collected_q + 32'd1;
				get_ptr_q             <= scan_nxt;
			end
			if (do_indone) in_fin_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrwd_pkg::S_IDLE && start) item_q <= item;
		if (fin) result_q <= res_d;
	end

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == rrwd_pkg::REG_ACTIVE_WORKERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 5'd16;
		end else if (cfg_wr) begin
			active_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == rrwd_pkg::REG_ACTIVE_WORKERS) ? {27'd0, active_q} : 32'd0;
	assign pready = 1'b1;
	assign busy   = (state_q != rrwd_pkg::S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	a_busy_fall_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("transaction ended without a result");

	a_done_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done_mask_q & free_mask_q) == '0)
		else $error("worker both free and done");

	a_collect_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == rrwd_pkg::STATUS_COLLECTED
		|-> collected_q == $past(collected_q) + 32'd1)
		else $error("collect did not advance count");

	a_dispatch_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == rrwd_pkg::STATUS_DISPATCHED
		|-> issued_q == $past(issued_q) + 32'd1)
		else $error("dispatch did not advance count");

endmodule
